FILE: hw/rtl/msw_pkg.sv
`default_nettype none

package msw_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned LOAD_W  = 10;
  localparam int unsigned LOW_W   = 4;
  localparam int unsigned FAULT_W = 6;
  localparam int unsigned GSTAT_W = 3;
  localparam int unsigned DRV_W   = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [CNT_W-1:0]  CNT_MAX = '1;
  localparam logic [LOW_W-1:0]  LOW_MAX = '1;

  // register reset values
  localparam logic [LOAD_W-1:0] RST_STALL_THRESHOLD = LOAD_W'(50);
  localparam logic [CNT_W-1:0]  RST_DIAG_INTERVAL   = CNT_W'(2000);
  localparam logic [CNT_W-1:0]  RST_STALL_INTERVAL  = CNT_W'(100);
  localparam logic [CNT_W-1:0]  RST_RAMP_GRACE      = CNT_W'(300);
  localparam logic [LOW_W-1:0]  RST_DEBOUNCE_LIMIT  = LOW_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE          = 3'd0,
    REG_STALL_ENABLE    = 3'd1,
    REG_STALL_THRESHOLD = 3'd2,
    REG_DIAG_INTERVAL   = 3'd3,
    REG_STALL_INTERVAL  = 3'd4,
    REG_RAMP_GRACE      = 3'd5,
    REG_DEBOUNCE_LIMIT  = 3'd6
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 2'd0,
    OP_CLEAR_STALL = 2'd1,
    OP_RESTART     = 2'd2
  } op_t;

  typedef struct packed {
    logic              enable;
    logic              stall_enable;
    logic [LOAD_W-1:0] stall_threshold;
    logic [CNT_W-1:0]  diag_interval;
    logic [CNT_W-1:0]  stall_interval;
    logic [CNT_W-1:0]  ramp_grace;
    logic [LOW_W-1:0]  debounce_limit;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic               running;
    logic               homing;
    logic [LOAD_W-1:0]  load_reading;
    logic [GSTAT_W-1:0] global_status;
    logic [DRV_W-1:0]   driver_status;
    logic               crc_error;
  } item_t;

  typedef struct packed {
    logic               stalled;
    logic               stop_motor;
    logic               homing_stall;
    logic               diag_sampled;
    logic               clear_request;
    logic               reset_seen;
    logic [FAULT_W-1:0] fault_flags;
    logic               link_crc_flag;
    logic [LOAD_W-1:0]  last_reading;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msw_cfg_regs.sv
`default_nettype none

module msw_cfg_regs
  import msw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b0;
      cfg.stall_enable    <= 1'b0;
      cfg.stall_threshold <= RST_STALL_THRESHOLD;
      cfg.diag_interval   <= RST_DIAG_INTERVAL;
      cfg.stall_interval  <= RST_STALL_INTERVAL;
      cfg.ramp_grace      <= RST_RAMP_GRACE;
      cfg.debounce_limit  <= RST_DEBOUNCE_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:          cfg.enable          <= cfg_data[0];
        REG_STALL_ENABLE:    cfg.stall_enable    <= cfg_data[0];
        REG_STALL_THRESHOLD: cfg.stall_threshold <= cfg_data[LOAD_W-1:0];
        REG_DIAG_INTERVAL:   cfg.diag_interval   <= cfg_data[CNT_W-1:0];
        REG_STALL_INTERVAL:  cfg.stall_interval  <= cfg_data[CNT_W-1:0];
        REG_RAMP_GRACE:      cfg.ramp_grace      <= cfg_data[CNT_W-1:0];
        REG_DEBOUNCE_LIMIT:  cfg.debounce_limit  <= cfg_data[LOW_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/msw_core.sv
`default_nettype none

module msw_core
  import msw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  step,   // apply item this cycle
  input  wire item_t item,
  output result_t    res
);

  logic [CNT_W-1:0]   ramp_elapsed, ramp_elapsed_next;
  logic [CNT_W-1:0]   stall_elapsed, stall_elapsed_next;
  logic [CNT_W-1:0]   diag_elapsed, diag_elapsed_next;
  logic               was_running, was_running_next;
  logic [LOW_W-1:0]   low_count, low_count_next;
  logic               stall_latch, stall_latch_next;
  logic               reset_latch, reset_latch_next;
  logic [FAULT_W-1:0] fault_latch, fault_latch_next;
  logic               crc_latch, crc_latch_next;
  logic [LOAD_W-1:0]  reading_latch, reading_latch_next;

  logic [CNT_W-1:0] ramp_inc, stall_inc, diag_inc;
  logic [LOW_W-1:0] low_inc;
  logic             stop, hstall, sampled, clr;

  assign ramp_inc  = (ramp_elapsed  == CNT_MAX) ? ramp_elapsed  : ramp_elapsed  + 1'b1;
  assign stall_inc = (stall_elapsed == CNT_MAX) ? stall_elapsed : stall_elapsed + 1'b1;
  assign diag_inc  = (diag_elapsed  == CNT_MAX) ? diag_elapsed  : diag_elapsed  + 1'b1;
  assign low_inc   = (low_count == LOW_MAX) ? low_count : low_count + 1'b1;

  always_comb begin
    ramp_elapsed_next  = ramp_elapsed;
    stall_elapsed_next = stall_elapsed;
    diag_elapsed_next  = diag_elapsed;
    was_running_next   = was_running;
    low_count_next     = low_count;
    stall_latch_next   = stall_latch;
    reset_latch_next   = reset_latch;
    fault_latch_next   = fault_latch;
    crc_latch_next     = crc_latch;
    reading_latch_next = reading_latch;
    stop    = 1'b0;
    hstall  = 1'b0;
    sampled = 1'b0;
    clr     = 1'b0;

    unique case (item.operation)
      OP_TICK: begin
        ramp_elapsed_next  = ramp_inc;
        stall_elapsed_next = stall_inc;
        diag_elapsed_next  = diag_inc;
        if (cfg.enable) begin
          // move start restarts the ramp window
          if (item.running && !was_running) begin
            ramp_elapsed_next = '0;
          end
          was_running_next = item.running;

          if (diag_inc >= cfg.diag_interval) begin
            diag_elapsed_next = '0;
            sampled           = 1'b1;
            reset_latch_next  = item.global_status[0];
            crc_latch_next    = item.crc_error;
            fault_latch_next  = {item.driver_status[7:6], item.driver_status[3:0]};
            clr               = |item.global_status;
          end

          if (cfg.stall_enable && item.running &&
              ramp_elapsed_next > cfg.ramp_grace &&
              stall_inc >= cfg.stall_interval) begin
            stall_elapsed_next = '0;
            reading_latch_next = item.load_reading;
            if (item.load_reading <= cfg.stall_threshold) begin
              low_count_next = low_inc;
              if (low_inc >= cfg.debounce_limit) begin
                if (item.homing) begin
                  hstall = 1'b1;
                end else begin
                  stop             = 1'b1;
                  stall_latch_next = 1'b1;
                end
              end
            end else begin
              low_count_next = '0;
            end
          end
        end
      end
      OP_CLEAR_STALL: begin
        stall_latch_next = 1'b0;
        low_count_next   = '0;
      end
      OP_RESTART: begin
        ramp_elapsed_next = '0;
        low_count_next    = '0;
        was_running_next  = item.running;
      end
      default: ; // unused code: report latches only
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_elapsed  <= '0;
      stall_elapsed <= '0;
      diag_elapsed  <= '0;
      was_running   <= 1'b0;
      low_count     <= '0;
      stall_latch   <= 1'b0;
      reset_latch   <= 1'b0;
      fault_latch   <= '0;
      crc_latch     <= 1'b0;
      reading_latch <= '0;
    end else if (step) begin
      ramp_elapsed  <= ramp_elapsed_next;
      stall_elapsed <= stall_elapsed_next;
      diag_elapsed  <= diag_elapsed_next;
      was_running   <= was_running_next;
      low_count     <= low_count_next;
      stall_latch   <= stall_latch_next;
      reset_latch   <= reset_latch_next;
      fault_latch   <= fault_latch_next;
      crc_latch     <= crc_latch_next;
      reading_latch <= reading_latch_next;
    end
  end

  always_comb begin
    res.stalled       = stall_latch_next;
    res.stop_motor    = stop;
    res.homing_stall  = hstall;
    res.diag_sampled  = sampled;
    res.clear_request = clr;
    res.reset_seen    = reset_latch_next;
    res.fault_flags   = fault_latch_next;
    res.link_crc_flag = crc_latch_next;
    res.last_reading  = reading_latch_next;
  end

  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    !(res.stop_motor && res.homing_stall))
    else $error("stop and homing stall fired together");

  a_stop_latches: assert property (@(posedge clk) disable iff (rst)
    step && res.stop_motor |=> stall_latch)
    else $error("stop pulse did not latch stalled");

  a_clear_low: assert property (@(posedge clk) disable iff (rst)
    step && (item.operation == OP_CLEAR_STALL || item.operation == OP_RESTART)
    |=> low_count == '0)
    else $error("command left low-sample count nonzero");

  a_poll_clears: assert property (@(posedge clk) disable iff (rst)
    step && res.diag_sampled |=> diag_elapsed == '0)
    else $error("poll did not restart diag timer");

endmodule

`default_nettype wire

FILE: hw/rtl/motor_stall_watchdog_unit.sv
// Motor stall watchdog: stall and driver-diagnostic supervisor, stepped by
// one beat per millisecond tick or per command.
// Input stream (s_*): s_tuser carries the operation (tick, clear stall,
// restart ramp timer); s_tdata carries the tick payload. Output stream
// (m_*): exactly one result beat per input beat, in order.
// Config port: cfg_we/cfg_index/cfg_data, one register per write, no
// read-back. Write only while the block is idle.
// A beat goes from the input register through the core into the result
// register and then shows on m_*. Throughput: one beat per cycle unless
// m_tready stalls; all per-beat work is one pass of counter increments
// and compares between the input and result registers.
// Stall: when m_tready is low the result register holds, the input register
// still takes one more beat, and s_tready then drops until the result
// drains (s_tready follows m_tready combinationally in that case).
// Reset (rst, synchronous): empties both registers, zeroes all timers and
// latches, restores the config registers to their defaults.
`default_nettype none

module motor_stall_watchdog_unit
  import msw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [0] running, [1] homing, [11:2] load_reading, [14:12] global_status,
  // [22:15] driver_status, [23] crc_error
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // [1:0] operation
  input  wire logic [OP_W-1:0]       s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [0] stalled, [1] stop_motor, [2] homing_stall, [3] diag_sampled,
  // [4] clear_request, [5] reset_seen, [11:6] fault_flags,
  // [12] link_crc_flag, [22:13] last_reading, [23] zero
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t core_res;
  result_t out_res;
  logic    advance;

  msw_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // move input beat into the core when the result slot is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.operation     <= s_tuser;
      in_item.running       <= s_tdata[0];
      in_item.homing        <= s_tdata[1];
      in_item.load_reading  <= s_tdata[11:2];
      in_item.global_status <= s_tdata[14:12];
      in_item.driver_status <= s_tdata[22:15];
      in_item.crc_error     <= s_tdata[23];
    end
  end

  msw_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .item (in_item),
    .res  (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {1'b0, out_res.last_reading, out_res.link_crc_flag,
                    out_res.fault_flags, out_res.reset_seen,
                    out_res.clear_request, out_res.diag_sampled,
                    out_res.homing_stall, out_res.stop_motor, out_res.stalled};

endmodule

`default_nettype wire
